>>> rtl/spda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spda_pkg
// Shared constants, register indexes and the arctangent table for the scaled
// point distance and angle block.
// ----------------------------------------------------------------------------
package spda_pkg;

    localparam int COORD_BITS_DEF    = 12;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_STAGES        = 24;

    localparam int SCALE_W    = 24;
    localparam int CFG_ADDR_W = 8;
    localparam int DIST_W     = 29;
    localparam int ANGLE_W    = 16;
    localparam int OUT_W      = ((DIST_W + ANGLE_W + 7) / 8) * 8;
    localparam int Z_W        = 34;
    localparam int GAIN_W     = 24;
    localparam int LO_W       = 20;

    localparam logic [CFG_ADDR_W-1:0] CFG_X_SCALE = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_Y_SCALE = CFG_ADDR_W'(1);

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'h01_0000;
    localparam logic [GAIN_W-1:0]  GAIN_Q24    = 24'd10188014;
    localparam logic [31:0]        HALF_PI_Q30 = 32'h6487_ED51;
    localparam logic [DIST_W-1:0]  DIST_MAX    = 29'h1FFF_FFFF;
    localparam int                 ANGLE_MAX   = 25736;

    function automatic logic [31:0] atan_q30(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h3243_F6A8;
            1:       v = 32'h1DAC_6705;
            2:       v = 32'h0FAD_BAFC;
            3:       v = 32'h07F5_6EA6;
            4:       v = 32'h03FE_AB76;
            5:       v = 32'h01FF_D55B;
            6:       v = 32'h00FF_FAAA;
            7:       v = 32'h007F_FF55;
            8:       v = 32'h003F_FFEA;
            9:       v = 32'h001F_FFFD;
            10:      v = 32'h000F_FFFF;
            11:      v = 32'h0007_FFFF;
            12:      v = 32'h0003_FFFF;
            13:      v = 32'h0001_FFFF;
            14:      v = 32'h0000_FFFF;
            15:      v = 32'h0000_7FFF;
            16:      v = 32'h0000_3FFF;
            17:      v = 32'h0000_1FFF;
            18:      v = 32'h0000_0FFF;
            19:      v = 32'h0000_07FF;
            20:      v = 32'h0000_03FF;
            21:      v = 32'h0000_01FF;
            22:      v = 32'h0000_00FF;
            23:      v = 32'h0000_007F;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/scaled_point_distance_angle.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scaled_point_distance_angle
// Scales the difference of two pixel points per axis and gives the distance
// and direction angle of the scaled vector from a pipelined CORDIC.
// ----------------------------------------------------------------------------
// Register stages: scaling, pre-rotation, one per CORDIC iteration, gain and
// rounding, in that order. Throughput is one request per cycle while the output
// is not stalled by m_tready.
// Each stage holds its request only while the stage after it is full.
// Reset clears all valid bits and sets both scale factors to 1.0.
// ----------------------------------------------------------------------------
module scaled_point_distance_angle #(
    parameter int COORD_BITS    = spda_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STAGES = spda_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [spda_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  wire logic [spda_pkg::SCALE_W-1:0]           cfg_wdata,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // Fields from bit 0: x_start, y_start, x_end, y_end.
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // Fields from bit 0: distance, angle.
    output logic [spda_pkg::OUT_W-1:0]                  m_tdata
);
    import spda_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int N  = CORDIC_STAGES;
    localparam int W  = CB + SCALE_W + 3;
    localparam int NS = N + 4;
    localparam int HI_W = W - LO_W;
    localparam int SW = W + 33;
    localparam int PROD_W = CB + SCALE_W + 2;
    localparam logic [SW-1:0] DIST_ROUND = SW'(64'h8000_0000);
    localparam logic signed [Z_W-1:0] ANGLE_ROUND = Z_W'(32'h0001_0000);
    localparam logic signed [Z_W-18:0] ANGLE_HI = (Z_W-17)'(ANGLE_MAX);
    localparam logic signed [Z_W-18:0] ANGLE_LO = -(Z_W-17)'(ANGLE_MAX);

    logic [SCALE_W-1:0] x_scale_reg;
    logic [SCALE_W-1:0] y_scale_reg;
    logic [NS-1:0]      vld_reg;
    logic [NS-1:0]      rdy;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_scale_reg <= SCALE_RESET;
            y_scale_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_X_SCALE)
            begin
                x_scale_reg <= cfg_wdata;
            end
            else if (cfg_addr == CFG_Y_SCALE)
            begin
                y_scale_reg <= cfg_wdata;
            end
        end
    end

    // A stage takes new data when it is empty or its successor moves on.
    genvar gk;
    generate
        for (gk = 0; gk < NS - 1; gk++)
        begin : g_rdy
            assign rdy[gk] = !vld_reg[gk] || rdy[gk+1];
        end
    endgenerate
    assign rdy[NS-1] = !vld_reg[NS-1] || m_tready;
    assign s_tready  = rdy[0];
    assign m_tvalid  = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= (k == 0) ? s_tvalid : vld_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // Stage 0: coordinate differences scaled per axis.
    logic [CB-1:0]            x_start;
    logic [CB-1:0]            y_start;
    logic [CB-1:0]            x_end;
    logic [CB-1:0]            y_end;
    logic signed [CB:0]       dpx;
    logic signed [CB:0]       dpy;
    logic signed [PROD_W-1:0] mx_next;
    logic signed [PROD_W-1:0] my_next;
    logic signed [W-1:0]      mx_reg;
    logic signed [W-1:0]      my_reg;

    assign x_start = s_tdata[CB-1:0];
    assign y_start = s_tdata[2*CB-1:CB];
    assign x_end   = s_tdata[3*CB-1:2*CB];
    assign y_end   = s_tdata[4*CB-1:3*CB];
    assign dpx     = signed'({1'b0, x_end}) - signed'({1'b0, x_start});
    assign dpy     = signed'({1'b0, y_end}) - signed'({1'b0, y_start});
    assign mx_next = dpx * signed'({1'b0, x_scale_reg});
    assign my_next = dpy * signed'({1'b0, y_scale_reg});

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            mx_reg <= W'(mx_next);
            my_reg <= W'(my_next);
        end
    end

    // Stage 1: zero test and turn into the right half plane.
    logic signed [W-1:0]   x_c_reg [N+1];
    logic signed [W-1:0]   y_c_reg [N+1];
    logic signed [Z_W-1:0] z_c_reg [N+1];
    logic                  zf_c_reg [N+1];

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            zf_c_reg[0] <= (mx_reg == '0) && (my_reg == '0);
            if (mx_reg[W-1])
            begin
                if (!my_reg[W-1])
                begin
                    x_c_reg[0] <= my_reg;
                    y_c_reg[0] <= -mx_reg;
                    z_c_reg[0] <= Z_W'(HALF_PI_Q30);
                end
                else
                begin
                    x_c_reg[0] <= -my_reg;
                    y_c_reg[0] <= mx_reg;
                    z_c_reg[0] <= -Z_W'(HALF_PI_Q30);
                end
            end
            else
            begin
                x_c_reg[0] <= mx_reg;
                y_c_reg[0] <= my_reg;
                z_c_reg[0] <= '0;
            end
        end
    end

    // CORDIC vectoring stages, one register stage per iteration.
    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cordic
            logic signed [W-1:0]   xs;
            logic signed [W-1:0]   ys;
            logic signed [Z_W-1:0] at;
            logic                  rot_cw;

            assign xs     = x_c_reg[gi] >>> gi;
            assign ys     = y_c_reg[gi] >>> gi;
            assign at     = signed'(Z_W'(atan_q30(gi)));
            assign rot_cw = !y_c_reg[gi][W-1] && (y_c_reg[gi] != '0);

            always_ff @(posedge clk)
            begin
                if (rdy[gi+2])
                begin
                    zf_c_reg[gi+1] <= zf_c_reg[gi];
                    if (rot_cw)
                    begin
                        x_c_reg[gi+1] <= x_c_reg[gi] + ys;
                        y_c_reg[gi+1] <= y_c_reg[gi] - xs;
                        z_c_reg[gi+1] <= z_c_reg[gi] + at;
                    end
                    else
                    begin
                        x_c_reg[gi+1] <= x_c_reg[gi] - ys;
                        y_c_reg[gi+1] <= y_c_reg[gi] + xs;
                        z_c_reg[gi+1] <= z_c_reg[gi] - at;
                    end
                end
            end
        end
    endgenerate

    // Gain stage: the magnitude is split in two partial products.
    logic [LO_W+GAIN_W-1:0] plo_reg;
    logic [HI_W+GAIN_W-1:0] phi_reg;
    logic signed [Z_W-1:0]  z_g_reg;
    logic                   zf_g_reg;
    logic [W-1:0]           x_fin;

    assign x_fin = x_c_reg[N];

    always_ff @(posedge clk)
    begin
        if (rdy[N+2])
        begin
            plo_reg  <= x_fin[LO_W-1:0] * GAIN_Q24;
            phi_reg  <= x_fin[W-1:LO_W] * GAIN_Q24;
            z_g_reg  <= z_c_reg[N];
            zf_g_reg <= zf_c_reg[N];
        end
    end

    // Output stage: rounding, saturation and clamping.
    logic [SW-1:0]           dsum;
    logic [SW-33:0]          dist_full;
    logic [DIST_W-1:0]       dist_next;
    logic signed [Z_W-1:0]   zr;
    logic signed [Z_W-18:0]  ang_full;
    logic signed [ANGLE_W-1:0] ang_next;
    logic [DIST_W-1:0]       dist_reg;
    logic signed [ANGLE_W-1:0] ang_reg;

    assign dsum      = (SW'(phi_reg) << LO_W) + SW'(plo_reg) + DIST_ROUND;
    assign dist_full = dsum[SW-1:32];
    assign zr        = z_g_reg + ANGLE_ROUND;
    assign ang_full  = zr[Z_W-1:17];

    always_comb
    begin
        if (dist_full > (SW-32)'(DIST_MAX))
        begin
            dist_next = DIST_MAX;
        end
        else
        begin
            dist_next = dist_full[DIST_W-1:0];
        end

        if (ang_full > ANGLE_HI)
        begin
            ang_next = ANGLE_W'(ANGLE_HI);
        end
        else if (ang_full < ANGLE_LO)
        begin
            ang_next = ANGLE_W'(ANGLE_LO);
        end
        else
        begin
            ang_next = ang_full[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[N+3])
        begin
            dist_reg <= zf_g_reg ? '0 : dist_next;
            ang_reg  <= zf_g_reg ? '0 : ang_next;
        end
    end

    assign m_tdata = {(OUT_W - DIST_W - ANGLE_W)'(0), ang_reg, dist_reg};

    // The input side is held off only while the first stage is occupied.
    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> vld_reg[0])
        else $error("input held off with an empty first stage");

    // A full stage whose successor is blocked keeps its request.
    a_stage_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NS-2] && !rdy[NS-1]) |=> vld_reg[NS-2])
        else $error("request lost in front of a blocked output stage");

    // A request in front of the output stage moves into it when that stage can take new data.
    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NS-2] && rdy[NS-1]) |=> vld_reg[NS-1])
        else $error("request not moved into the output stage");

    // The delivered angle stays within plus and minus pi.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((ang_reg <= ANGLE_W'(ANGLE_HI)) && (ang_reg >= ANGLE_W'(ANGLE_LO))))
        else $error("angle out of range");

endmodule
`default_nettype wire
